// ===== rtl/lcm_pkg.sv =====
// ----------------------------------------------------------------------------
// lcm_pkg
// Shared types and constants for the cube map texel lighting block.
// ----------------------------------------------------------------------------
package lcm_pkg;

    localparam int CW       = 10;
    localparam int SQW      = 20;
    localparam int ACCW     = 36;
    localparam int PIPE_LAT = 8;

    localparam logic [2:0] CFG_MODE      = 3'd0;
    localparam logic [2:0] CFG_INDOORS   = 3'd1;
    localparam logic [2:0] CFG_AMBIENT   = 3'd2;
    localparam logic [2:0] CFG_SUN_DIR   = 3'd3;
    localparam logic [2:0] CFG_SUN_COLOR = 3'd4;
    localparam logic [2:0] CFG_COUNT     = 3'd5;

    localparam logic [1:0] MODE_LIGHT = 2'd1;
    localparam logic [1:0] MODE_SPEC  = 2'd2;

    localparam logic [47:0] AMBIENT_RESET = 48'h0800_0800_0800;

    localparam logic KIND_LOAD = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [2:0]  face;
        logic [5:0]  pixel_x;
        logic [5:0]  pixel_y;
        logic [3:0]  light_slot;
        logic signed [15:0] light_dir_x;
        logic signed [15:0] light_dir_y;
        logic signed [15:0] light_dir_z;
        logic [15:0] light_red;
        logic [15:0] light_green;
        logic [15:0] light_blue;
        logic [1:0]  light_flags;
    } in_item_t;

    typedef struct packed {
        logic [7:0] texel_red;
        logic [7:0] texel_green;
        logic [7:0] texel_blue;
    } out_item_t;

    typedef struct packed {
        logic [1:0]  flags;
        logic [47:0] color;
        logic [47:0] dir;
    } light_t;

    typedef struct packed {
        logic        contrib;
        logic [47:0] color;
        logic [47:0] dir;
    } elem_t;

endpackage

// ===== rtl/lcm_cell.sv =====
// ----------------------------------------------------------------------------
// lcm_cell
// One light table entry of the rotating light ring.
// ----------------------------------------------------------------------------
module lcm_cell
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            shift,
    input  logic            wr_en,
    input  lcm_pkg::light_t wr_light,
    input  lcm_pkg::light_t prev,
    output lcm_pkg::light_t q
);

    logic [1:0]  flags_reg;
    logic [47:0] color_reg;
    logic [47:0] dir_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= 2'b00;
        end
        else if (wr_en)
        begin
            flags_reg <= wr_light.flags;
        end
        else if (shift)
        begin
            flags_reg <= prev.flags;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            color_reg <= wr_light.color;
            dir_reg   <= wr_light.dir;
        end
        else if (shift)
        begin
            color_reg <= prev.color;
            dir_reg   <= prev.dir;
        end
    end

    assign q = '{flags: flags_reg, color: color_reg, dir: dir_reg};

endmodule

// ===== rtl/lcm_norm.sv =====
// ----------------------------------------------------------------------------
// lcm_norm
// Pixel direction normalizer: bit-serial square root, then three restoring
// dividers in parallel giving Q1.14 components.
// ----------------------------------------------------------------------------
module lcm_norm
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic signed [lcm_pkg::CW-1:0]    vec [3],
    input  logic [lcm_pkg::SQW-1:0]          sumsq,
    output logic                             done,
    output logic [47:0]                      normal
);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_SQRT = 2'd1;
    localparam logic [1:0] PH_DIV  = 2'd2;

    logic [1:0]  phase_reg, phase_next;
    logic [3:0]  step_reg, step_next;
    logic        done_reg, done_next;

    logic [47:0] rem_reg, root_reg, bit_reg;
    logic [47:0] trial, rem_sq_next, root_sq_next;
    logic        sq_ge;
    logic [23:0] len;

    logic [lcm_pkg::CW-1:0] mag_reg [3];
    logic [2:0]             sign_reg;
    logic [39:0]            num_reg [3];
    logic [39:0]            num_next [3];
    logic [39:0]            num_init [3];
    logic [39:0]            den_reg;
    logic [15:0]            quo_reg [3];
    logic [15:0]            quo_next [3];
    logic [47:0]            normal_reg, normal_next;
    logic [14:0]            qmag [3];

    always_comb
    begin
        trial        = root_reg + bit_reg;
        sq_ge        = rem_reg >= trial;
        rem_sq_next  = sq_ge ? rem_reg - trial : rem_reg;
        root_sq_next = sq_ge ? (root_reg >> 1) + bit_reg : root_reg >> 1;
        len          = (root_sq_next[23:0] == 24'd0) ? 24'd1 : root_sq_next[23:0];
        for (int k = 0; k < 3; k++)
        begin
            num_init[k] = (40'(mag_reg[k]) << 28) + 40'(len >> 1);
            if (num_reg[k] >= den_reg)
            begin
                num_next[k] = num_reg[k] - den_reg;
                quo_next[k] = {quo_reg[k][14:0], 1'b1};
            end
            else
            begin
                num_next[k] = num_reg[k];
                quo_next[k] = {quo_reg[k][14:0], 1'b0};
            end
            qmag[k] = (quo_next[k] > 16'd16384) ? 15'd16384 : quo_next[k][14:0];
            normal_next[16*k +: 16] = sign_reg[k] ? -{1'b0, qmag[k]} : {1'b0, qmag[k]};
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        step_next  = step_reg;
        done_next  = 1'b0;
        unique case (phase_reg)
            PH_SQRT:
            begin
                if (bit_reg[0])
                begin
                    phase_next = PH_DIV;
                    step_next  = 4'd0;
                end
            end
            PH_DIV:
            begin
                step_next = step_reg + 4'd1;
                if (step_reg == 4'd15)
                begin
                    phase_next = PH_IDLE;
                    done_next  = 1'b1;
                end
            end
            default:
            begin
                if (start)
                begin
                    phase_next = PH_SQRT;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            step_reg  <= 4'd0;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            step_reg  <= step_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (phase_reg == PH_IDLE && start)
        begin
            rem_reg  <= {sumsq, 28'd0};
            root_reg <= 48'd0;
            bit_reg  <= 48'd1 << 46;
            for (int k = 0; k < 3; k++)
            begin
                sign_reg[k] <= vec[k][lcm_pkg::CW-1];
                mag_reg[k]  <= vec[k][lcm_pkg::CW-1] ? -vec[k] : vec[k];
            end
        end
        else if (phase_reg == PH_SQRT)
        begin
            rem_reg  <= rem_sq_next;
            root_reg <= root_sq_next;
            bit_reg  <= bit_reg >> 2;
            if (bit_reg[0])
            begin
                den_reg <= 40'(len) << 15;
                for (int k = 0; k < 3; k++)
                begin
                    num_reg[k] <= num_init[k];
                    quo_reg[k] <= 16'd0;
                end
            end
        end
        else if (phase_reg == PH_DIV)
        begin
            den_reg <= den_reg >> 1;
            for (int k = 0; k < 3; k++)
            begin
                num_reg[k] <= num_next[k];
                quo_reg[k] <= quo_next[k];
            end
            if (step_reg == 4'd15)
            begin
                normal_reg <= normal_next;
            end
        end
    end

    assign done   = done_reg;
    assign normal = normal_reg;

endmodule

// ===== rtl/lcm_shade.sv =====
// ----------------------------------------------------------------------------
// lcm_shade
// Shading pipeline: dot product, clamp, optional 16th power, colour weight
// and accumulate, one light per cycle.
// ----------------------------------------------------------------------------
module lcm_shade
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       init,
    input  logic                       spec,
    input  logic [47:0]                ambient,
    input  logic [47:0]                normal,
    input  lcm_pkg::elem_t             elem,
    output logic [lcm_pkg::ACCW-1:0]   acc [3]
);

    logic               s0_c_reg;
    logic [47:0]        s0_col_reg;
    logic [47:0]        s0_dir_reg;

    logic signed [31:0] prod_reg [3];
    logic [47:0]        col1_reg;
    logic               c1_reg;

    logic signed [33:0] dot;
    logic [19:0]        dot_sh;
    logic [14:0]        w_dot;
    logic [14:0]        w2_reg;
    logic [47:0]        col2_reg;
    logic               c2_reg;

    logic [14:0]        sq_w_reg [4];
    logic [47:0]        sq_col_reg [4];
    logic               sq_c_reg [4];

    logic [30:0]        cprod_reg [3];
    logic               c7_reg;

    logic [lcm_pkg::ACCW-1:0] acc_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_c_reg <= 1'b0;
            c1_reg   <= 1'b0;
            c2_reg   <= 1'b0;
            c7_reg   <= 1'b0;
        end
        else
        begin
            s0_c_reg <= elem.contrib;
            c1_reg   <= s0_c_reg;
            c2_reg   <= c1_reg;
            c7_reg   <= sq_c_reg[3];
        end
    end

    always_ff @(posedge clk)
    begin
        s0_col_reg <= elem.color;
        s0_dir_reg <= elem.dir;
        for (int k = 0; k < 3; k++)
        begin
            prod_reg[k] <= $signed(s0_dir_reg[16*k +: 16]) * $signed(normal[16*k +: 16]);
        end
        col1_reg <= s0_col_reg;
    end

    always_comb
    begin
        dot    = 34'(prod_reg[0]) + 34'(prod_reg[1]) + 34'(prod_reg[2]);
        dot_sh = dot[33:14];
        if (dot <= 34'sd0)
        begin
            w_dot = 15'd0;
        end
        else if (dot_sh > 20'd16384)
        begin
            w_dot = 15'd16384;
        end
        else
        begin
            w_dot = dot_sh[14:0];
        end
    end

    always_ff @(posedge clk)
    begin
        w2_reg   <= w_dot;
        col2_reg <= col1_reg;
    end

    for (genvar j = 0; j < 4; j++)
    begin : g_sq
        logic [14:0] w_in;
        logic [47:0] col_in;
        logic        c_in;
        logic [29:0] sq;

        if (j == 0)
        begin : g_first
            assign w_in   = w2_reg;
            assign col_in = col2_reg;
            assign c_in   = c2_reg;
        end
        else
        begin : g_rest
            assign w_in   = sq_w_reg[j-1];
            assign col_in = sq_col_reg[j-1];
            assign c_in   = sq_c_reg[j-1];
        end

        assign sq = 30'(w_in) * 30'(w_in) + 30'd8192;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sq_c_reg[j] <= 1'b0;
            end
            else
            begin
                sq_c_reg[j] <= c_in;
            end
        end

        always_ff @(posedge clk)
        begin
            sq_w_reg[j]   <= spec ? sq[28:14] : w_in;
            sq_col_reg[j] <= col_in;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            cprod_reg[k] <= 31'(sq_col_reg[3][16*k +: 16]) * 31'(sq_w_reg[3]);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            if (init)
            begin
                acc_reg[k] <= spec ? '0 : lcm_pkg::ACCW'({ambient[16*k +: 16], 14'd0});
            end
            else if (c7_reg)
            begin
                acc_reg[k] <= acc_reg[k] + lcm_pkg::ACCW'(cprod_reg[k]);
            end
        end
    end

    assign acc = acc_reg;

endmodule

// ===== rtl/cube_map_texel_lighting.sv =====
// ----------------------------------------------------------------------------
// cube_map_texel_lighting
// Bakes one texel of a directional-light cube map per texel item.
// ----------------------------------------------------------------------------
// A load item writes one light into the table and gives no result. A texel
// item first runs the bit-serial square root and then the dividers that
// normalize the pixel direction; then the light ring rotates its entries,
// and the sun after them, through the shading pipeline, which then drains.
// One item is in work at a time; a finished texel waits in the output
// register while the next item is taken.
module cube_map_texel_lighting
#(
    parameter int FACE_SIZE  = 64,
    parameter int MAX_LIGHTS = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  lcm_pkg::in_item_t   in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output lcm_pkg::out_item_t  out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [47:0]         cfg_data
);

    localparam int LAST = MAX_LIGHTS + lcm_pkg::PIPE_LAT;
    localparam int CNTW = $clog2(LAST + 1);
    localparam int CMPW = (CNTW > 5) ? CNTW : 5;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_NORM = 2'd1;
    localparam logic [1:0] ST_RUN  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]  state_reg, state_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;

    logic [1:0]  mode_reg;
    logic        indoors_reg;
    logic [47:0] ambient_reg;
    logic [47:0] sun_dir_reg;
    logic [47:0] sun_color_reg;
    logic [4:0]  count_reg;

    logic        in_fire, load_fire, texel_fire, done_load;
    logic        spec, light_mode, shift;

    logic signed [lcm_pkg::CW-1:0] a, b;
    logic signed [lcm_pkg::CW-1:0] vec [3];
    logic [lcm_pkg::SQW-1:0]       sumsq;
    logic signed [2*lcm_pkg::CW-1:0] sq [3];

    logic        norm_done;
    logic [47:0] normal;

    lcm_pkg::light_t cell_q [MAX_LIGHTS];
    lcm_pkg::light_t wr_light;
    lcm_pkg::elem_t  elem;
    logic            head_use;

    logic [lcm_pkg::ACCW-1:0]   acc [3];
    logic [lcm_pkg::ACCW+7:0]   scaled [3];
    logic [lcm_pkg::ACCW-19:0]  byte_wide [3];
    logic [7:0]                 byte_val [3];

    logic        out_valid_reg;
    lcm_pkg::out_item_t out_data_reg;

    assign in_stall   = state_reg != ST_IDLE;
    assign in_fire    = in_valid && !in_stall;
    assign load_fire  = in_fire && in_data.kind == lcm_pkg::KIND_LOAD;
    assign texel_fire = in_fire && in_data.kind != lcm_pkg::KIND_LOAD;
    assign cfg_ready  = 1'b1;

    assign spec       = mode_reg == lcm_pkg::MODE_SPEC;
    assign light_mode = mode_reg == lcm_pkg::MODE_LIGHT && !indoors_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= 2'd0;
            indoors_reg   <= 1'b0;
            ambient_reg   <= lcm_pkg::AMBIENT_RESET;
            sun_dir_reg   <= 48'd0;
            sun_color_reg <= 48'd0;
            count_reg     <= 5'd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                lcm_pkg::CFG_MODE:      mode_reg      <= cfg_data[1:0];
                lcm_pkg::CFG_INDOORS:   indoors_reg   <= cfg_data[0];
                lcm_pkg::CFG_AMBIENT:   ambient_reg   <= cfg_data;
                lcm_pkg::CFG_SUN_DIR:   sun_dir_reg   <= cfg_data;
                lcm_pkg::CFG_SUN_COLOR: sun_color_reg <= cfg_data;
                lcm_pkg::CFG_COUNT:     count_reg     <= cfg_data[4:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        a = $signed({{(lcm_pkg::CW-7){1'b0}}, in_data.pixel_x, 1'b1})
            - lcm_pkg::CW'(FACE_SIZE);
        b = $signed({{(lcm_pkg::CW-7){1'b0}}, in_data.pixel_y, 1'b1})
            - lcm_pkg::CW'(FACE_SIZE);
        unique case (in_data.face)
            3'd0:
            begin
                vec[0] = lcm_pkg::CW'(FACE_SIZE);  vec[1] = -b; vec[2] = -a;
            end
            3'd1:
            begin
                vec[0] = -lcm_pkg::CW'(FACE_SIZE); vec[1] = -b; vec[2] = a;
            end
            3'd2:
            begin
                vec[0] = a; vec[1] = lcm_pkg::CW'(FACE_SIZE);  vec[2] = b;
            end
            3'd3:
            begin
                vec[0] = a; vec[1] = -lcm_pkg::CW'(FACE_SIZE); vec[2] = -b;
            end
            3'd4:
            begin
                vec[0] = a; vec[1] = -b; vec[2] = lcm_pkg::CW'(FACE_SIZE);
            end
            default:
            begin
                vec[0] = -a; vec[1] = -b; vec[2] = -lcm_pkg::CW'(FACE_SIZE);
            end
        endcase
        for (int k = 0; k < 3; k++)
        begin
            sq[k] = vec[k] * vec[k];
        end
        sumsq = lcm_pkg::SQW'(sq[0]) + lcm_pkg::SQW'(sq[1]) + lcm_pkg::SQW'(sq[2]);
    end

    lcm_norm u_norm
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (texel_fire),
        .vec    (vec),
        .sumsq  (sumsq),
        .done   (norm_done),
        .normal (normal)
    );

    assign wr_light = '{
        flags: in_data.light_flags,
        color: {in_data.light_blue, in_data.light_green, in_data.light_red},
        dir:   {in_data.light_dir_z, in_data.light_dir_y, in_data.light_dir_x}
    };

    assign shift = state_reg == ST_RUN && cnt_reg < CNTW'(MAX_LIGHTS);

    for (genvar i = 0; i < MAX_LIGHTS; i++)
    begin : g_ring
        lcm_cell u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .shift    (shift),
            .wr_en    (load_fire && 32'(in_data.light_slot) == i),
            .wr_light (wr_light),
            .prev     (cell_q[(i + 1) % MAX_LIGHTS]),
            .q        (cell_q[i])
        );
    end

    always_comb
    begin
        head_use = spec ? cell_q[0].flags[1] : cell_q[0].flags[0];
        elem     = '{contrib: 1'b0, color: cell_q[0].color, dir: cell_q[0].dir};
        if (state_reg == ST_RUN)
        begin
            if (cnt_reg < CNTW'(MAX_LIGHTS))
            begin
                elem.contrib = head_use && (CMPW'(cnt_reg) < CMPW'(count_reg));
            end
            else if (cnt_reg == CNTW'(MAX_LIGHTS))
            begin
                elem = '{contrib: light_mode, color: sun_color_reg, dir: sun_dir_reg};
            end
        end
    end

    lcm_shade u_shade
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .init    (state_reg == ST_NORM),
        .spec    (spec),
        .ambient (ambient_reg),
        .normal  (normal),
        .elem    (elem),
        .acc     (acc)
    );

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (texel_fire)
                begin
                    state_next = ST_NORM;
                end
            end
            ST_NORM:
            begin
                if (norm_done)
                begin
                    state_next = ST_RUN;
                    cnt_next   = '0;
                end
            end
            ST_RUN:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNTW'(LAST))
                begin
                    state_next = ST_DONE;
                end
            end
            default:
            begin
                if (done_load)
                begin
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            scaled[k]    = {acc[k], 8'd0} - (lcm_pkg::ACCW + 8)'(acc[k]);
            byte_wide[k] = light_mode ? (lcm_pkg::ACCW - 18)'(scaled[k] >> 28)
                                      : (lcm_pkg::ACCW - 18)'(scaled[k] >> 26);
            byte_val[k]  = (byte_wide[k] > (lcm_pkg::ACCW - 18)'(255))
                           ? 8'd255 : byte_wide[k][7:0];
        end
    end

    assign done_load = state_reg == ST_DONE && (!out_valid_reg || !out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (done_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done_load)
        begin
            out_data_reg <= '{texel_red: byte_val[0], texel_green: byte_val[1],
                              texel_blue: byte_val[2]};
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_DONE)
        else $error("result raised outside the done state");

    a_norm_in_norm: assert property (@(posedge clk) disable iff (!rst_n)
        norm_done |-> state_reg == ST_NORM)
        else $error("normalizer finished while not awaited");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RUN |-> cnt_reg <= CNTW'(LAST))
        else $error("light ring counter overran");

endmodule
